/* src/jse_pkg.sv */
// Package for the JSON string escaper: register indexes, character codes,
// the word descriptor passed from the front end to the back end, and helpers.
// No dependencies.
package jse_pkg;

	localparam int IDX_W = 4;

	localparam logic [1:0] MODE_RAW  = 2'd0;
	localparam logic [1:0] MODE_JSON = 2'd2;

	localparam logic CFG_ESCAPE_MODE = 1'b0;
	localparam logic CFG_ADD_QUOTES  = 1'b1;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_U      = 8'h75;

	typedef enum logic [2:0] {
		BK_NONE,
		BK_LIT,
		BK_ESC,
		BK_HEX,
		BK_UNI,
		BK_DOT
	} body_kind_t;

	typedef struct packed {
		logic             quote_open;
		logic [1:0]       pre_dots;
		body_kind_t       kind;
		logic [2:0]       lit_len;
		logic [3:0][7:0]  body;
		logic [1:0]       post_dots;
		logic             quote_close;
		logic             str_last;
	} jse_desc_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		if (n < 4'd10) begin
			return CH_ZERO + {4'd0, n};
		end
		return CH_UPPER_A + {4'd0, n} - 8'd10;
	endfunction

	function automatic logic [2:0] body_len(input jse_desc_t d);
		case (d.kind)
			BK_LIT:  return d.lit_len;
			BK_ESC:  return 3'd2;
			BK_HEX:  return 3'd4;
			BK_UNI:  return 3'd6;
			BK_DOT:  return 3'd1;
			default: return 3'd0;
		endcase
	endfunction

	function automatic logic [7:0] body_byte(input jse_desc_t d, input logic [2:0] j);
		logic [7:0] b;
		b = d.body[0];
		case (d.kind)
			BK_LIT: begin
				return d.body[j[1:0]];
			end
			BK_ESC: begin
				return (j == 3'd0) ? CH_BSLASH : b;
			end
			BK_HEX: begin
				case (j)
					3'd0:    return CH_BSLASH;
					3'd1:    return CH_X;
					3'd2:    return hex_digit(b[7:4]);
					default: return hex_digit(b[3:0]);
				endcase
			end
			BK_UNI: begin
				case (j)
					3'd0:    return CH_BSLASH;
					3'd1:    return CH_U;
					3'd2:    return CH_ZERO;
					3'd3:    return CH_ZERO;
					3'd4:    return hex_digit(b[7:4]);
					default: return hex_digit(b[3:0]);
				endcase
			end
			default: begin
				return CH_DOT;
			end
		endcase
	endfunction

endpackage

/* src/jse_front.sv */
// Front end: accepts source bytes, tracks the UTF-8 sequence state and
// classifies each word into a descriptor for the back end.
// Depends on jse_pkg.
module jse_front
	import jse_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       escape_mode,
	input  logic             add_quotes,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_char,
	input  logic             char_present,
	input  logic             string_first,
	input  logic             string_last,
	output logic             push,
	output jse_desc_t        push_desc,
	input  logic             push_ready
);

	logic [7:0] lead_q;
	logic [1:0] need_q;
	logic [1:0] held_q;
	logic [7:0] tail_q [2];

	logic [7:0] lead_d;
	logic [1:0] need_d;
	logic [1:0] held_d;
	logic       tail_wr;
	logic       tail_idx;
	logic       accept;
	logic       nonempty;
	jse_desc_t  d;

	always_comb begin
		logic       json;
		logic       raw;
		logic [7:0] lo;
		logic [7:0] hi;
		logic       esc;
		logic [7:0] letter;

		json = (escape_mode == MODE_JSON);
		raw = (escape_mode == MODE_RAW);
		d = '0;
		d.kind = BK_NONE;
		lead_d = lead_q;
		need_d = need_q;
		held_d = held_q;
		tail_wr = 1'b0;
		tail_idx = held_q[0];
		lo = 8'h80;
		hi = 8'hBF;
		esc = 1'b0;
		letter = 8'h00;

		if (string_first) begin
			need_d = 2'd0;
			held_d = 2'd0;
			d.quote_open = add_quotes;
		end

		if (char_present) begin
			if (held_d == 2'd0) begin
				if (lead_q == 8'hE0) begin
					lo = 8'hA0;
				end else if (lead_q == 8'hF0) begin
					lo = 8'h90;
				end
				if (lead_q == 8'hED) begin
					hi = 8'h9F;
				end else if (lead_q == 8'hF4) begin
					hi = 8'h8F;
				end
			end
			if (need_d != 2'd0 && json && in_char >= lo && in_char <= hi) begin
				if ({1'b0, held_d} + 3'd1 >= {1'b0, need_d}) begin
					d.kind = BK_LIT;
					d.lit_len = {1'b0, held_d} + 3'd2;
					d.body[0] = lead_q;
					case (held_d)
						2'd0: begin
							d.body[1] = in_char;
						end
						2'd1: begin
							d.body[1] = tail_q[0];
							d.body[2] = in_char;
						end
						default: begin
							d.body[1] = tail_q[0];
							d.body[2] = tail_q[1];
							d.body[3] = in_char;
						end
					endcase
					need_d = 2'd0;
					held_d = 2'd0;
				end else begin
					tail_wr = 1'b1;
					tail_idx = held_d[0];
					held_d = held_d + 2'd1;
				end
			end else begin
				if (need_d != 2'd0) begin
					d.pre_dots = held_d + 2'd1;
					need_d = 2'd0;
					held_d = 2'd0;
				end
				if (raw) begin
					d.kind = BK_LIT;
					d.lit_len = 3'd1;
					d.body[0] = in_char;
				end else begin
					case (in_char)
						CH_BSLASH: begin esc = 1'b1; letter = CH_BSLASH; end
						CH_QUOTE:  begin esc = 1'b1; letter = CH_QUOTE; end
						8'h0A:     begin esc = 1'b1; letter = 8'h6E; end
						8'h0D:     begin esc = 1'b1; letter = 8'h72; end
						8'h09:     begin esc = 1'b1; letter = 8'h74; end
						8'h0C:     begin esc = 1'b1; letter = 8'h66; end
						8'h08:     begin esc = 1'b1; letter = 8'h62; end
						8'h0B:     begin esc = !json; letter = 8'h76; end
						default:   begin esc = 1'b0; letter = 8'h00; end
					endcase
					if (esc) begin
						d.kind = BK_ESC;
						d.body[0] = letter;
					end else if (in_char >= 8'h20 && in_char < 8'h7F) begin
						d.kind = BK_LIT;
						d.lit_len = 3'd1;
						d.body[0] = in_char;
					end else if (json) begin
						if (in_char < 8'h20 || in_char == 8'h7F) begin
							d.kind = BK_UNI;
							d.body[0] = in_char;
						end else if (in_char <= 8'hC1 || in_char >= 8'hF5) begin
							d.kind = BK_DOT;
						end else begin
							lead_d = in_char;
							held_d = 2'd0;
							if (in_char <= 8'hDF) begin
								need_d = 2'd1;
							end else if (in_char <= 8'hEF) begin
								need_d = 2'd2;
							end else begin
								need_d = 2'd3;
							end
						end
					end else begin
						d.kind = BK_HEX;
						d.body[0] = in_char;
					end
				end
			end
		end

		if (string_last) begin
			if (need_d != 2'd0) begin
				d.post_dots = held_d + 2'd1;
			end
			need_d = 2'd0;
			held_d = 2'd0;
			d.quote_close = add_quotes;
			d.str_last = 1'b1;
		end
	end

	assign nonempty = d.quote_open || (d.pre_dots != 2'd0) || (d.kind != BK_NONE) ||
		(d.post_dots != 2'd0) || d.quote_close;
	assign in_ready = push_ready;
	assign accept = in_valid && push_ready;
	assign push = accept && nonempty;
	assign push_desc = d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= 8'h00;
			need_q <= 2'd0;
			held_q <= 2'd0;
		end else if (accept) begin
			lead_q <= lead_d;
			need_q <= need_d;
			held_q <= held_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && tail_wr) begin
			tail_q[tail_idx] <= in_char;
		end
	end

endmodule

/* src/jse_queue.sv */
// Descriptor queue between the front end and the back end.
// Depends on jse_pkg.
module jse_queue
	import jse_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  jse_desc_t push_desc,
	output logic      push_ready,
	input  logic      pop,
	output jse_desc_t head_desc,
	output logic      head_valid
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	jse_desc_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (cnt_q != FULL_CNT);
	assign head_valid = (cnt_q != '0);
	assign head_desc = mem_q[rd_q];
	assign do_push = push && push_ready;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

/* src/jse_back.sv */
// Back end: expands the head descriptor into output bytes, one per cycle
// unless out_ready stalls it, into a registered output stage.
// Depends on jse_pkg.
module jse_back
	import jse_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  jse_desc_t head_desc,
	input  logic      head_valid,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output logic [7:0] out_char,
	output logic      run_last,
	output logic      string_done
);

	logic [IDX_W-1:0] idx_q;
	logic             ov_q;
	logic [7:0]       char_q;
	logic             run_last_q;
	logic             done_q;

	logic [IDX_W-1:0] e0;
	logic [IDX_W-1:0] e1;
	logic [IDX_W-1:0] e2;
	logic [IDX_W-1:0] e3;
	logic [IDX_W-1:0] cnt;
	logic [IDX_W-1:0] jrel;
	logic [7:0]       cur;
	logic             is_end;
	logic             load;

	assign e0 = {{(IDX_W-1){1'b0}}, head_desc.quote_open};
	assign e1 = e0 + {{(IDX_W-2){1'b0}}, head_desc.pre_dots};
	assign e2 = e1 + {{(IDX_W-3){1'b0}}, body_len(head_desc)};
	assign e3 = e2 + {{(IDX_W-2){1'b0}}, head_desc.post_dots};
	assign cnt = e3 + {{(IDX_W-1){1'b0}}, head_desc.quote_close};
	assign jrel = idx_q - e1;

	always_comb begin
		if (idx_q < e0) begin
			cur = CH_QUOTE;
		end else if (idx_q < e1) begin
			cur = CH_DOT;
		end else if (idx_q < e2) begin
			cur = body_byte(head_desc, jrel[2:0]);
		end else if (idx_q < e3) begin
			cur = CH_DOT;
		end else begin
			cur = CH_QUOTE;
		end
	end

	assign is_end = (idx_q == cnt - IDX_W'(1));
	assign load = head_valid && (!ov_q || out_ready);
	assign pop = load && is_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (load) begin
				ov_q <= 1'b1;
				idx_q <= is_end ? '0 : idx_q + IDX_W'(1);
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= cur;
			run_last_q <= is_end;
			done_q <= is_end && head_desc.str_last;
		end
	end

	assign out_valid = ov_q;
	assign out_char = char_q;
	assign run_last = run_last_q;
	assign string_done = done_q;

endmodule

/* src/json_string_escaper_utf8.sv */
// Top level of the JSON string escaper with UTF-8 check: configuration
// registers, front end, descriptor queue and back end.
// Depends on jse_pkg, jse_front, jse_queue, jse_back.
//
//   port group | direction | handshake           | words
//   in         | sink      | in_valid/in_ready   | in_char, char_present, string_first, string_last
//   out        | source    | out_valid/out_ready | out_char, run_last, string_done
//   cfg        | sink      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Input takes one word per cycle while the descriptor queue has room.
// Output gives one byte per cycle while out_ready is high; a word expands to 0..10
// bytes, so the sustained input rate is set by the back end's one-byte-per-cycle expander.
// With the queue empty and the output register free, an accepted input word is written
// into the descriptor queue and then loaded into the output register, raising out_valid.
// Reset clears sequence state and the queue; escape_mode resets to JSON and
// add_quotes to 1. Either side may stall without blocking the other until
// the queue of QUEUE_DEPTH descriptors fills or drains.
module json_string_escaper_utf8
	import jse_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       char_present,
	input  logic       string_first,
	input  logic       string_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       run_last,
	output logic       string_done,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [1:0] cfg_data
);

	logic [1:0] escape_mode_q;
	logic       add_quotes_q;
	logic       push;
	logic       push_ready;
	logic       pop;
	logic       head_valid;
	jse_desc_t  push_desc;
	jse_desc_t  head_desc;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_mode_q <= MODE_JSON;
			add_quotes_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ESCAPE_MODE: escape_mode_q <= cfg_data;
				CFG_ADD_QUOTES:  add_quotes_q <= cfg_data[0];
				default:         add_quotes_q <= add_quotes_q;
			endcase
		end
	end

	jse_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.escape_mode  (escape_mode_q),
		.add_quotes   (add_quotes_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_char      (in_char),
		.char_present (char_present),
		.string_first (string_first),
		.string_last  (string_last),
		.push         (push),
		.push_desc    (push_desc),
		.push_ready   (push_ready)
	);

	jse_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.push_ready (push_ready),
		.pop        (pop),
		.head_desc  (head_desc),
		.head_valid (head_valid)
	);

	jse_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_desc   (head_desc),
		.head_valid  (head_valid),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char),
		.run_last    (run_last),
		.string_done (string_done)
	);

endmodule
